[design/rlst_pkg.sv]
package rlst_pkg;

    localparam int MaxItems  = 1024;
    localparam int LeafBits  = 10;
    localparam int NodeBits  = LeafBits + 1;
    localparam int LenBits   = 11;
    localparam int LcmBits   = 63;
    localparam logic [LcmBits-1:0] LcmSat = {LcmBits{1'b1}};
    localparam logic [LcmBits-1:0] LcmOne = {{(LcmBits-1){1'b0}}, 1'b1};
    localparam logic [LenBits-1:0] LenReset = LenBits'(MaxItems);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_WRITE,
        ST_UPD_READ,
        ST_UPD_WAIT,
        ST_UPD_COMB,
        ST_Q_STEP,
        ST_Q_READ,
        ST_Q_WAIT,
        ST_Q_COMB,
        ST_OUT
    } rlst_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_GCD,
        C_DIV,
        C_MUL,
        C_FIN,
        C_DONE
    } rlst_comb_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_UPD_LEAF,
        OP_UPD_READ,
        OP_UPD_COMB,
        OP_Q_READ,
        OP_Q_COMB
    } rlst_op_t;

    typedef struct packed {
        rlst_op_t op;
        logic     start;
    } rlst_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_query;
        logic upd_skip;
        logic upd_at_root;
        logic q_empty;
        logic q_done;
        logic q_pick;
        logic comb_done;
    } rlst_stat_t;

endpackage

[design/rlst_combine.sv]
// Iterative LCM combine: zero/flag checks, binary GCD, shift-subtract divide,
// then a 63x63 product built from 32-bit partial products over cycles.
module rlst_combine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [rlst_pkg::LcmBits-1:0]    a_in,
    input  logic                            fa_in,
    input  logic [rlst_pkg::LcmBits-1:0]    b_in,
    input  logic                            fb_in,
    output logic                            done,
    output logic [rlst_pkg::LcmBits-1:0]    r_out,
    output logic                            rf_out
);
    rlst_pkg::rlst_comb_state_t cst_reg, cst_next;

    logic [62:0] a_reg, b_reg, ga_reg, gb_reg, g_reg, q_reg, rem_reg;
    logic [62:0] ga_next, gb_next, g_next, q_next, rem_next;
    logic [5:0]  sh_reg, sh_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]  pp_reg, pp_next;
    logic [62:0] r_reg, r_next;
    logic        rf_reg, rf_next;
    logic [63:0] trial;
    logic [31:0] mx, my;
    logic [63:0] pprod;
    logic [62:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cst_reg <= rlst_pkg::C_IDLE;
        end else begin
            cst_reg <= cst_next;
        end
        ga_reg <= ga_next; gb_reg <= gb_next; g_reg <= g_next;
        q_reg <= q_next; rem_reg <= rem_next; sh_reg <= sh_next;
        cnt_reg <= cnt_next; acc_reg <= acc_next; pp_reg <= pp_next;
        r_reg <= r_next; rf_reg <= rf_next;
        if (start) begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
    end

    always_comb begin
        mx = '0;
        my = '0;
        unique case (pp_reg)
            2'd0: begin mx = q_reg[31:0];              my = b_reg[31:0]; end
            2'd1: begin mx = q_reg[31:0];              my = {1'b0, b_reg[62:32]}; end
            2'd2: begin mx = {1'b0, q_reg[62:32]};    my = b_reg[31:0]; end
            default: begin mx = {1'b0, q_reg[62:32]}; my = {1'b0, b_reg[62:32]}; end
        endcase
        pprod = mx * my;
        diff = (ga_reg > gb_reg) ? ga_reg - gb_reg : gb_reg - ga_reg;
        trial = {rem_reg, q_reg[62]} - {1'b0, g_reg};
    end

    always_comb begin
        cst_next = cst_reg;
        ga_next = ga_reg; gb_next = gb_reg; g_next = g_reg; q_next = q_reg;
        rem_next = rem_reg; sh_next = sh_reg; cnt_next = cnt_reg;
        acc_next = acc_reg; pp_next = pp_reg; r_next = r_reg; rf_next = rf_reg;
        unique case (cst_reg)
            rlst_pkg::C_IDLE: begin
                if (start) begin
                    if (a_in == '0 || b_in == '0) begin
                        r_next = '0; rf_next = 1'b0; cst_next = rlst_pkg::C_DONE;
                    end else if (fa_in || fb_in) begin
                        r_next = rlst_pkg::LcmSat; rf_next = 1'b1;
                        cst_next = rlst_pkg::C_DONE;
                    end else begin
                        ga_next = a_in; gb_next = b_in; sh_next = '0;
                        cst_next = rlst_pkg::C_GCD;
                    end
                end
            end
            rlst_pkg::C_GCD: begin
                // Stein: strip common twos, then odd halving and subtraction
                if (ga_reg == gb_reg) begin
                    g_next = ga_reg << sh_reg;
                    q_next = a_reg; rem_next = '0; cnt_next = '0;
                    cst_next = rlst_pkg::C_DIV;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1; gb_next = gb_reg >> 1; sh_next = sh_reg + 6'd1;
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (ga_reg > gb_reg) begin
                    ga_next = diff >> 1;
                end else begin
                    gb_next = diff >> 1;
                end
            end
            rlst_pkg::C_DIV: begin
                if (!trial[63]) begin
                    rem_next = trial[62:0];
                    q_next = {q_reg[61:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[61:0], q_reg[62]};
                    q_next = {q_reg[61:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd62) begin
                    acc_next = '0; pp_next = '0; cst_next = rlst_pkg::C_MUL;
                end
            end
            rlst_pkg::C_MUL: begin
                unique case (pp_reg)
                    2'd0: acc_next = acc_reg + {64'd0, pprod};
                    2'd1, 2'd2: acc_next = acc_reg + {32'd0, pprod, 32'd0};
                    default: acc_next = acc_reg + {pprod, 64'd0};
                endcase
                pp_next = pp_reg + 2'd1;
                if (pp_reg == 2'd3) cst_next = rlst_pkg::C_FIN;
            end
            rlst_pkg::C_FIN: begin
                if (acc_reg[127:63] != '0) begin
                    r_next = rlst_pkg::LcmSat; rf_next = 1'b1;
                end else begin
                    r_next = acc_reg[62:0]; rf_next = 1'b0;
                end
                cst_next = rlst_pkg::C_DONE;
            end
            default: cst_next = rlst_pkg::C_IDLE;
        endcase
    end

    assign done   = (cst_reg == rlst_pkg::C_DONE);
    assign r_out  = r_reg;
    assign rf_out = rf_reg;
endmodule

[design/rlst_datapath.sv]
module rlst_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rlst_pkg::rlst_cmd_t            cmd,
    output rlst_pkg::rlst_stat_t           stat,
    input  logic                           s_mode,
    input  logic [9:0]                     s_index,
    input  logic [30:0]                    s_value,
    input  logic [9:0]                     s_first,
    input  logic [9:0]                     s_last,
    input  logic [rlst_pkg::LenBits-1:0]   len_cfg,
    output logic [rlst_pkg::LcmBits-1:0]   res_lcm,
    output logic                           res_ovf
);
    localparam int NodeCount = 2 * rlst_pkg::MaxItems;
    localparam int NB = rlst_pkg::NodeBits;

    logic [rlst_pkg::LcmBits:0] mem [NodeCount];
    logic [NB-1:0] waddr;
    logic [rlst_pkg::LcmBits:0] wdata;
    logic          wen;
    logic [NB-1:0] raddr;
    logic [rlst_pkg::LcmBits:0] rdata_reg;

    logic [NB-1:0] k_reg, k_next, clr_reg, clr_next;
    logic [NB:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic          side_reg, side_next;
    logic          mode_reg;
    logic [9:0]    idx_reg;
    logic [30:0]   val_reg;
    logic [rlst_pkg::LcmBits-1:0] acc_reg, acc_next;
    logic          accf_reg, accf_next;
    logic [rlst_pkg::LenBits-1:0] n_eff;

    logic          c_start, c_done, c_rf;
    logic [rlst_pkg::LcmBits-1:0] c_a, c_b, c_r;
    logic          c_fa, c_fb;

    always_comb begin
        if (len_cfg == '0) n_eff = 11'd1;
        else if (len_cfg > rlst_pkg::LenReset) n_eff = rlst_pkg::LenReset;
        else n_eff = len_cfg;
    end

    function automatic logic [9:0] last_clip_in();
        logic [10:0] lim;
        lim = n_eff - 11'd1;
        return ({1'b0, s_last} > lim) ? lim[9:0] : s_last;
    endfunction

    // Memory access mux
    always_comb begin
        wen = 1'b0; waddr = k_reg; wdata = '0; raddr = '0;
        unique case (cmd.op)
            rlst_pkg::OP_CLEAR: begin
                wen = 1'b1; waddr = clr_reg; wdata = {1'b0, rlst_pkg::LcmOne};
            end
            rlst_pkg::OP_UPD_LEAF: begin
                wen = 1'b1; waddr = {1'b1, idx_reg};
                wdata = {1'b0, 32'd0, val_reg};
            end
            rlst_pkg::OP_UPD_READ: raddr = k_reg ^ NB'(1);
            rlst_pkg::OP_UPD_COMB: begin
                wen = c_done; waddr = k_reg >> 1; wdata = {c_rf, c_r};
            end
            rlst_pkg::OP_Q_READ: raddr = side_reg ? NB'(hi_reg - 1'b1) : lo_reg[NB-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wen) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        k_next = k_reg; clr_next = clr_reg; lo_next = lo_reg; hi_next = hi_reg;
        side_next = side_reg; acc_next = acc_reg; accf_next = accf_reg;
        unique case (cmd.op)
            rlst_pkg::OP_CLEAR: clr_next = clr_reg + NB'(1);
            rlst_pkg::OP_LOAD: begin
                k_next = {1'b1, s_index};
                lo_next = (NB+1)'(rlst_pkg::MaxItems) + (NB+1)'(s_first);
                acc_next = rlst_pkg::LcmOne; accf_next = 1'b0;
            end
            rlst_pkg::OP_UPD_COMB: if (c_done) k_next = k_reg >> 1;
            rlst_pkg::OP_Q_READ: ;
            rlst_pkg::OP_Q_COMB: begin
                if (c_done) begin
                    acc_next = c_r; accf_next = c_rf;
                    if (!side_reg) begin
                        lo_next = lo_reg + (NB+1)'(1);
                    end else begin
                        hi_next = hi_reg - (NB+1)'(1);
                    end
                end
            end
            default: ;
        endcase
        // Advance walk: pick lo side, then hi side, then go up a level
        if (cmd.start) begin
            if (lo_reg[0] && lo_reg < hi_reg) side_next = 1'b0;
            else if (hi_reg[0] && lo_reg < hi_reg) side_next = 1'b1;
            else begin
                lo_next = lo_reg >> 1; hi_next = hi_reg >> 1;
            end
        end
        if (cmd.op == rlst_pkg::OP_LOAD) begin
            hi_next = (NB+1)'(rlst_pkg::MaxItems) + (NB+1)'(last_clip_in()) + (NB+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else begin
            clr_reg <= clr_next;
        end
        k_reg <= k_next; lo_reg <= lo_next; hi_reg <= hi_next; side_reg <= side_next;
        acc_reg <= acc_next; accf_reg <= accf_next;
        if (cmd.op == rlst_pkg::OP_LOAD) begin
            mode_reg <= s_mode; idx_reg <= s_index; val_reg <= s_value;
        end
    end

    // Update: combine the sibling read from memory with the node value just
    // written, which is held in cur_reg.
    always_comb begin
        c_start = (cmd.op == rlst_pkg::OP_UPD_COMB || cmd.op == rlst_pkg::OP_Q_COMB)
                  && cmd.start;
        c_a = acc_reg; c_fa = accf_reg;
        c_b = rdata_reg[rlst_pkg::LcmBits-1:0]; c_fb = rdata_reg[rlst_pkg::LcmBits];
    end

    logic [rlst_pkg::LcmBits-1:0] cur_reg;
    logic cur_f_reg;
    always_ff @(posedge aclk) begin
        if (cmd.op == rlst_pkg::OP_UPD_LEAF) begin
            cur_reg <= {32'd0, val_reg}; cur_f_reg <= 1'b0;
        end else if (cmd.op == rlst_pkg::OP_UPD_COMB && c_done) begin
            cur_reg <= c_r; cur_f_reg <= c_rf;
        end
    end

    rlst_combine u_comb (
        .aclk(aclk), .aresetn(aresetn), .start(c_start),
        .a_in(mode_reg ? c_a : cur_reg), .fa_in(mode_reg ? c_fa : cur_f_reg),
        .b_in(c_b), .fb_in(c_fb),
        .done(c_done), .r_out(c_r), .rf_out(c_rf)
    );

    always_comb begin
        stat.clear_done  = (clr_reg == NB'(NodeCount - 1));
        stat.is_query    = s_mode;
        stat.upd_skip    = ({1'b0, s_index} >= n_eff);
        // the combine now finishing writes the root when k is 2 or 3
        stat.upd_at_root = (k_reg[NB-1:1] == (NB-1)'(1));
        stat.q_empty     = (s_first > last_clip_in());
        stat.q_done      = !(lo_reg < hi_reg);
        stat.q_pick      = (lo_reg < hi_reg) && (lo_reg[0] || hi_reg[0]);
        stat.comb_done   = c_done;
    end

    assign res_lcm = acc_reg;
    assign res_ovf = accf_reg;
endmodule

[design/rlst_ctrl.sv]
module rlst_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  cfg_ready,
    output rlst_pkg::rlst_cmd_t   cmd,
    input  rlst_pkg::rlst_stat_t  stat
);
    rlst_pkg::rlst_state_t st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= rlst_pkg::ST_CLEAR;
        else st_reg <= st_next;
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            rlst_pkg::ST_CLEAR: if (stat.clear_done) st_next = rlst_pkg::ST_IDLE;
            rlst_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (stat.is_query)
                        st_next = stat.q_empty ? rlst_pkg::ST_OUT : rlst_pkg::ST_Q_STEP;
                    else if (!stat.upd_skip) st_next = rlst_pkg::ST_UPD_WRITE;
                end
            end
            rlst_pkg::ST_UPD_WRITE: st_next = rlst_pkg::ST_UPD_READ;
            rlst_pkg::ST_UPD_READ:  st_next = rlst_pkg::ST_UPD_WAIT;
            rlst_pkg::ST_UPD_WAIT:  st_next = rlst_pkg::ST_UPD_COMB;
            rlst_pkg::ST_UPD_COMB: if (stat.comb_done)
                st_next = stat.upd_at_root ? rlst_pkg::ST_IDLE : rlst_pkg::ST_UPD_READ;
            rlst_pkg::ST_Q_STEP: begin
                if (stat.q_done) st_next = rlst_pkg::ST_OUT;
                else if (stat.q_pick) st_next = rlst_pkg::ST_Q_READ;
            end
            rlst_pkg::ST_Q_READ: st_next = rlst_pkg::ST_Q_WAIT;
            rlst_pkg::ST_Q_WAIT: st_next = rlst_pkg::ST_Q_COMB;
            rlst_pkg::ST_Q_COMB: if (stat.comb_done) st_next = rlst_pkg::ST_Q_STEP;
            rlst_pkg::ST_OUT: if (out_ready) st_next = rlst_pkg::ST_IDLE;
            default: st_next = rlst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op = rlst_pkg::OP_NONE;
        cmd.start = 1'b0;
        in_ready = 1'b0; out_valid = 1'b0; cfg_ready = 1'b0;
        unique case (st_reg)
            rlst_pkg::ST_CLEAR: cmd.op = rlst_pkg::OP_CLEAR;
            rlst_pkg::ST_IDLE: begin
                in_ready = 1'b1; cfg_ready = !in_valid;
                if (in_valid) cmd.op = rlst_pkg::OP_LOAD;
            end
            rlst_pkg::ST_UPD_WRITE: cmd.op = rlst_pkg::OP_UPD_LEAF;
            rlst_pkg::ST_UPD_READ:  cmd.op = rlst_pkg::OP_UPD_READ;
            rlst_pkg::ST_UPD_WAIT:  begin cmd.op = rlst_pkg::OP_UPD_COMB; cmd.start = 1'b1; end
            rlst_pkg::ST_UPD_COMB:  cmd.op = rlst_pkg::OP_UPD_COMB;
            rlst_pkg::ST_Q_STEP:    cmd.start = !stat.q_done;
            rlst_pkg::ST_Q_READ:    cmd.op = rlst_pkg::OP_Q_READ;
            rlst_pkg::ST_Q_WAIT:    begin cmd.op = rlst_pkg::OP_Q_COMB; cmd.start = 1'b1; end
            rlst_pkg::ST_Q_COMB:    cmd.op = rlst_pkg::OP_Q_COMB;
            rlst_pkg::ST_OUT:       out_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != rlst_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready |-> (st_reg == rlst_pkg::ST_IDLE)) else $error("cfg while busy");
`endif
endmodule

[design/range_lcm_segment_tree_top.sv]
// Channel | Dir | Fields (low bit first)
// s_axis  | in  | tdata: index[9:0] value[40:10] range_first[50:41] range_last[60:51]; tuser: mode
// m_axis  | out | tdata: range_lcm[62:0] overflowed[63]
// cfg     | in  | length_in_use[10:0]
// After reset a clearing pass sets every node to 1; no transaction is taken meanwhile.
// One combine: a zero operand gives 0, else a flagged operand gives the saturated result;
// otherwise binary GCD, a 63-step divide and 4 partial products.
// Update: leaf write, then 10 levels of a sibling read, a wait and a combine;
// query: up to 20 combines plus one walk step per level.
// The single combine unit is shared by update and query. One item at a time.
module range_lcm_segment_tree_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // index, value, range_first, range_last, pad
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // range_lcm, overflowed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);
    rlst_pkg::rlst_cmd_t  cmd;
    rlst_pkg::rlst_stat_t stat;
    logic [rlst_pkg::LenBits-1:0] len_reg;
    logic [rlst_pkg::LcmBits-1:0] res_lcm;
    logic res_ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) len_reg <= rlst_pkg::LenReset;
        else if (cfg_valid && cfg_ready) len_reg <= cfg_data;
    end

    rlst_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cfg_ready(cfg_ready),
        .cmd(cmd), .stat(stat)
    );

    rlst_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_mode(s_tuser), .s_index(s_tdata[9:0]), .s_value(s_tdata[40:10]),
        .s_first(s_tdata[50:41]), .s_last(s_tdata[60:51]), .len_cfg(len_reg),
        .res_lcm(res_lcm), .res_ovf(res_ovf)
    );

    assign m_tdata = {res_ovf, res_lcm};
endmodule
